// ===== rtl/ide_pkg.sv =====
// ----------------------------------------------------------------------------
// ide_pkg
// Shared widths, request codes and memory request type for the indexed
// double-ended queue engine.
// ----------------------------------------------------------------------------
package ide_pkg;

  // storage geometry
  localparam int DEPTH   = 16;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // payload widths fixed by the request and response formats
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 3;
  localparam int POS_W   = 4;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ       = 3'd4,
    REQ_WRITE      = 3'd5
  } req_type_e;

  // one access to the element memory
  typedef struct packed {
    logic                     en;
    logic                     we;
    logic [SLOT_W-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/ide_req_if.sv =====
// ----------------------------------------------------------------------------
// ide_req_if
// Request channel: valid/ready handshake carrying one deque request.
// ----------------------------------------------------------------------------
interface ide_req_if;

  logic                              valid;
  logic                              ready;
  logic [ide_pkg::REQ_W-1:0]         req_type;
  logic [ide_pkg::POS_W-1:0]         position;
  logic signed [ide_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output req_type, output position, output data_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_in,
                  output ready);

endinterface

// ===== rtl/ide_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ide_rsp_if
// Response channel: valid/ready handshake carrying one deque result.
// ----------------------------------------------------------------------------
interface ide_rsp_if;

  logic                              valid;
  logic                              ready;
  logic signed [ide_pkg::DATA_W-1:0] data_out;
  logic                              ok;
  logic [ide_pkg::COUNT_W-1:0]       count;

  modport source (output valid, output data_out, output ok, output count,
                  input ready);
  modport sink   (input valid, input data_out, input ok, input count,
                  output ready);

endinterface

// ===== rtl/ide_ring_mem.sv =====
// ----------------------------------------------------------------------------
// ide_ring_mem
// Single-port element store of the ring, synchronous write and registered
// read data, one access per cycle.
// ----------------------------------------------------------------------------
module ide_ring_mem (
  input  logic                              clk_i,
  input  ide_pkg::mem_req_t                 mem_req_i,
  output logic signed [ide_pkg::DATA_W-1:0] rdata_o
);

  logic signed [ide_pkg::DATA_W-1:0] mem_q [ide_pkg::DEPTH];
  logic signed [ide_pkg::DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.en && mem_req_i.we) begin
      mem_q[mem_req_i.addr] <= mem_req_i.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (mem_req_i.en && !mem_req_i.we) begin
      rdata_q <= mem_q[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/indexed_deque_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_deque_engine
// Bounded double-ended queue of signed words with read and write by
// position, kept as a ring in a single-port memory addressed front + position.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------
//  req_i   | in  | valid/ready  | req_type[3], position[4], data_in[32]
//  rsp_o   | out | valid/ready  | data_out[32], ok[1], count[5]
//
// One request per cycle sustained while responses are taken; the memory is
// accessed at the request transfer edge, and the result passes the memory
// stage and then the output register before it is offered. The single memory
// port takes one access per request, which sets that rate.
// Reset empties the queue (front and count cleared); no clearing pass.
// A stalled response holds the output register; one more request can sit in
// the memory stage behind it before req_i.ready drops.
// ----------------------------------------------------------------------------
module indexed_deque_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  ide_req_if.sink   req_i,
  ide_rsp_if.source rsp_o
);

  localparam int SUM_W = ide_pkg::COUNT_W + 1;

  // ring slot of element number off counted from front
  function automatic logic [ide_pkg::SLOT_W-1:0] slot_of(
    input logic [ide_pkg::SLOT_W-1:0]  front,
    input logic [ide_pkg::COUNT_W-1:0] off
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(front) + SUM_W'(off);
    if (sum >= SUM_W'(ide_pkg::DEPTH)) begin
      sum = sum - SUM_W'(ide_pkg::DEPTH);
    end
    return sum[ide_pkg::SLOT_W-1:0];
  endfunction

  // queue state
  logic [ide_pkg::SLOT_W-1:0]  front_q, front_d;
  logic [ide_pkg::COUNT_W-1:0] count_q, count_d;

  // memory stage
  logic                        s1_valid_q;
  logic                        s1_ok_q, s1_ok_d;
  logic                        s1_rd_q, s1_rd_d;
  logic [ide_pkg::COUNT_W-1:0] s1_count_q;

  // output register
  logic                              out_valid_q;
  logic signed [ide_pkg::DATA_W-1:0] out_data_q;
  logic                              out_ok_q;
  logic [ide_pkg::COUNT_W-1:0]       out_count_q;

  ide_pkg::mem_req_t                 mem_req;
  logic signed [ide_pkg::DATA_W-1:0] mem_rdata;

  logic                        req_xfer;
  logic                        s1_adv;
  logic                        full;
  logic                        empty;
  logic                        pos_ok;
  logic [ide_pkg::COUNT_W-1:0] pos_ext;
  ide_pkg::req_type_e          req_code;

  // handshake
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_xfer    = req_i.valid && req_i.ready;

  assign full     = (count_q == ide_pkg::COUNT_W'(ide_pkg::DEPTH));
  assign empty    = (count_q == '0);
  assign pos_ext  = ide_pkg::COUNT_W'(req_i.position);
  assign pos_ok   = (pos_ext < count_q);
  assign req_code = ide_pkg::req_type_e'(req_i.req_type);

  // request decode: memory access and next front and count
  always_comb begin
    front_d       = front_q;
    count_d       = count_q;
    s1_ok_d       = 1'b0;
    s1_rd_d       = 1'b0;
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = front_q;
    mem_req.wdata = req_i.data_in;
    unique case (req_code)
      ide_pkg::REQ_PUSH_BACK: begin
        if (!full) begin
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = slot_of(front_q, count_q);
          count_d      = count_q + 1'b1;
          s1_ok_d      = 1'b1;
        end
      end
      ide_pkg::REQ_PUSH_FRONT: begin
        if (!full) begin
          front_d      = (front_q == '0) ? ide_pkg::SLOT_W'(ide_pkg::DEPTH - 1)
                                         : front_q - 1'b1;
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = front_d;
          count_d      = count_q + 1'b1;
          s1_ok_d      = 1'b1;
        end
      end
      ide_pkg::REQ_POP_BACK: begin
        if (!empty) begin
          mem_req.en   = 1'b1;
          mem_req.addr = slot_of(front_q, count_q - 1'b1);
          count_d      = count_q - 1'b1;
          s1_ok_d      = 1'b1;
          s1_rd_d      = 1'b1;
        end
      end
      ide_pkg::REQ_POP_FRONT: begin
        if (!empty) begin
          mem_req.en   = 1'b1;
          mem_req.addr = front_q;
          front_d      = slot_of(front_q, ide_pkg::COUNT_W'(1));
          count_d      = count_q - 1'b1;
          s1_ok_d      = 1'b1;
          s1_rd_d      = 1'b1;
        end
      end
      ide_pkg::REQ_READ: begin
        if (pos_ok) begin
          mem_req.en   = 1'b1;
          mem_req.addr = slot_of(front_q, pos_ext);
          s1_ok_d      = 1'b1;
          s1_rd_d      = 1'b1;
        end
      end
      ide_pkg::REQ_WRITE: begin
        if (pos_ok) begin
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = slot_of(front_q, pos_ext);
          s1_ok_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // nothing happens without a transfer
    if (!req_xfer) begin
      mem_req.en = 1'b0;
    end
  end

  ide_ring_mem u_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (mem_rdata)
  );

  // queue state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (req_xfer) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // memory stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // memory stage payload
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      s1_ok_q    <= s1_ok_d;
      s1_rd_q    <= s1_rd_d;
      s1_count_q <= count_d;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q  <= s1_rd_q ? mem_rdata : '0;
      out_ok_q    <= s1_ok_q;
      out_count_q <= s1_count_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.ok       = out_ok_q;
  assign rsp_o.count    = out_count_q;

endmodule

// ===== tb/sv/deque_result_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_check
// Watches the request and result channels of the deque engine, keeps its own
// ring copy of the queue, works out the result of every accepted request and
// compares each result transfer field by field with the oldest one pending.
// ----------------------------------------------------------------------------
module deque_result_check
  import ide_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  ide_req_if                 req_mon_i,
  ide_rsp_if                 rsp_mon_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output logic [COUNT_W-1:0] level_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     ok;
    logic [COUNT_W-1:0]       count;
  } deque_result_t;

  // shadow ring and its pointers
  logic signed [DATA_W-1:0] word_ring [DEPTH];
  logic [SLOT_W-1:0]        front_q;
  logic [COUNT_W-1:0]       level_q;

  // results still owed by the block, oldest first
  deque_result_t            owed_q[$];
  deque_result_t            owed_r;

  // apply one request to the shadow ring and return its result
  function automatic deque_result_t apply_request(input logic [REQ_W-1:0]         op,
                                                  input logic [POS_W-1:0]         pos,
                                                  input logic signed [DATA_W-1:0] word);
    deque_result_t     r;
    logic [SLOT_W-1:0] slot;
    r = '0;
    case (op)
      REQ_PUSH_BACK: begin
        if (level_q < DEPTH) begin
          slot            = front_q + SLOT_W'(level_q);
          word_ring[slot] = word;
          level_q         = level_q + 1'b1;
          r.ok            = 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (level_q < DEPTH) begin
          front_q            = front_q - 1'b1;
          word_ring[front_q] = word;
          level_q            = level_q + 1'b1;
          r.ok               = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (level_q > 0) begin
          slot       = front_q + SLOT_W'(level_q - 1'b1);
          r.data_out = word_ring[slot];
          level_q    = level_q - 1'b1;
          r.ok       = 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (level_q > 0) begin
          r.data_out = word_ring[front_q];
          front_q    = front_q + 1'b1;
          level_q    = level_q - 1'b1;
          r.ok       = 1'b1;
        end
      end
      REQ_READ: begin
        if (COUNT_W'(pos) < level_q) begin
          slot       = front_q + SLOT_W'(pos);
          r.data_out = word_ring[slot];
          r.ok       = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (COUNT_W'(pos) < level_q) begin
          slot            = front_q + SLOT_W'(pos);
          word_ring[slot] = word;
          r.ok            = 1'b1;
        end
      end
      // spare codes leave everything alone
      default: ;
    endcase
    r.count = level_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q.delete();
      front_q    = '0;
      level_q    = '0;
      fail_cnt_o = 0;
    end else begin
      // result transfer: belongs to an older request, so handled first
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (owed_q.size() == 0) begin
          $error("result transfer with none pending: data_out %0d ok %0b count %0d",
                 rsp_mon_i.data_out, rsp_mon_i.ok, rsp_mon_i.count);
          fail_cnt_o++;
        end else begin
          owed_r = owed_q.pop_front();
          if (rsp_mon_i.data_out !== owed_r.data_out) begin
            $error("data_out: expected %0d actual %0d", owed_r.data_out, rsp_mon_i.data_out);
            fail_cnt_o++;
          end
          if (rsp_mon_i.ok !== owed_r.ok) begin
            $error("ok: expected %0b actual %0b", owed_r.ok, rsp_mon_i.ok);
            fail_cnt_o++;
          end
          if (rsp_mon_i.count !== owed_r.count) begin
            $error("count: expected %0d actual %0d", owed_r.count, rsp_mon_i.count);
            fail_cnt_o++;
          end
        end
      end
      // request transfer: predict its result
      if (req_mon_i.valid && req_mon_i.ready) begin
        owed_q.push_back(apply_request(req_mon_i.req_type, req_mon_i.position,
                                       req_mon_i.data_in));
      end
    end
    pending_o = owed_q.size();
    level_o   = level_q;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the deque engine testbench: clock, reset, request stimulus and a
// randomly stalling result receiver. A directed run covers empty, full and
// out-of-range cases, then random phases walk the queue between empty and
// full under different idling. Checking is done in deque_result_check.
// ----------------------------------------------------------------------------
module tb;
  import ide_pkg::*;

  localparam int                 PERIOD          = 8;
  localparam int                 ITEMS_PER_PHASE = 475;
  localparam int                 HOLD_CYCLES     = 64;
  localparam int                 HOLD_AT_ITEM    = 100;
  localparam logic [REQ_W-1:0]   REQ_SPARE_LO    = 3'd6;
  localparam logic [REQ_W-1:0]   REQ_SPARE_HI    = 3'd7;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  int                 src_idle_pct;
  int                 snk_stall_pct;
  bit                 hold_req;
  bit                 toward_full;
  int                 fail_cnt;
  int                 pending;
  logic [COUNT_W-1:0] level;

  ide_req_if req_if ();
  ide_rsp_if rsp_if ();

  indexed_deque_engine i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  deque_result_check i_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_mon_i  (req_if),
    .rsp_mon_i  (rsp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .level_o    (level)
  );

  // clock
  always #(PERIOD / 2) clk = ~clk;

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result receiver: random stalls, or a long hold-off when asked
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // edge values of a signed word, or a random one
  function automatic logic [DATA_W-1:0] pick_word(input bit edge_val);
    if (!edge_val) return $urandom();
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // offer one request and wait for its transfer; ends on a falling edge
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= op;
    req_if.position <= pos;
    req_if.data_in  <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering until every result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // one random request, steered to swing the fill level between the ends
  task automatic send_random();
    int                roll;
    logic [REQ_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    if (level == DEPTH) toward_full = 1'b0;
    else if (level == 0) toward_full = 1'b1;
    else if ($urandom_range(99) < 3) toward_full = ~toward_full;
    roll = $urandom_range(99);
    if (roll < 2) begin
      op = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    end else if (roll < 50) begin
      if (toward_full) op = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
      else             op = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
    end else if (roll < 65) begin
      if (toward_full) op = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_BACK;
      else             op = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    end else begin
      op = $urandom_range(1) ? REQ_WRITE : REQ_READ;
    end
    // mostly a live position, sometimes anything
    if (level > 0 && $urandom_range(9) < 8) pos = POS_W'($urandom_range(level - 1));
    else                                     pos = POS_W'($urandom_range(15));
    send_req(op, pos, pick_word($urandom_range(7) == 0));
  endtask

  // stimulus and verdict
  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_PUSH_BACK;
    req_if.position = '0;
    req_if.data_in  = '0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    hold_req        = 1'b0;
    toward_full     = 1'b1;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty queue: pops, read and spare code all refused
    send_req(REQ_POP_BACK, '0, 32'h1234_5678);
    send_req(REQ_POP_FRONT, '0, 32'h1234_5678);
    send_req(REQ_READ, '0, '0);
    send_req(REQ_SPARE_HI, 4'hf, 32'hffff_ffff);
    // fill from both ends, edge words first
    for (int i = 0; i < DEPTH; i++) begin
      send_req(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, POS_W'(i),
               (i < 4) ? pick_word(1'b1) : pick_word(1'b0));
    end
    // full queue refuses both pushes
    send_req(REQ_PUSH_BACK, '0, 32'h7fff_ffff);
    send_req(REQ_PUSH_FRONT, '0, 32'h8000_0000);
    // last position, then out of range once one element is gone
    send_req(REQ_WRITE, 4'hf, 32'h8000_0000);
    send_req(REQ_READ, 4'hf, '0);
    send_req(REQ_POP_FRONT, '0, '0);
    send_req(REQ_READ, 4'hf, '0);
    send_req(REQ_WRITE, 4'hf, 32'h7fff_ffff);
    wait_drained();

    // random phases with different idling on each side
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 76; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 76; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while requests keep coming
        if (phase == 0 && n == HOLD_AT_ITEM) hold_req = 1'b1;
        send_random();
      end
      wait_drained();
    end

    snk_stall_pct = 0;
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ide_pkg.sv
rtl/ide_req_if.sv
rtl/ide_rsp_if.sv
rtl/ide_ring_mem.sv
rtl/indexed_deque_engine.sv
tb/sv/deque_result_check.sv
tb/sv/tb.sv
